// ===== rtl/skl_pkg.sv =====
// Shared types and constants for the skyline rectangle packer.
// Used by the controller, datapath and top level; no dependencies.
package skl_pkg;

   localparam int MAX_SEGMENTS_DEF = 256;
   localparam int DIM_W = 16;
   localparam int AREA_W = 32;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = 8'd1;

   localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST = 16'd512;
   localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = 16'd512;

   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] w;
   } seg_type;

   localparam int SEG_W = $bits(seg_type);

   typedef enum logic [1:0] {
      RESP_FAIL,
      RESP_PLACE,
      RESP_CLEAR
   } resp_kind_type;

   typedef struct packed {
      logic          load_req;
      logic          init_border;
      logic          scan_start;
      logic          start_rd;
      logic          start_ev;
      logic          next_start;
      logic          walk_rd;
      logic          walk_ev;
      logic          copy_init;
      logic          copy_rd;
      logic          copy_ev;
      logic          flush;
      logic          area_mul;
      logic          area_add;
      logic          resp_load;
      resp_kind_type resp_kind;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic zero_or_full;
      logic i_done;
      logic x_fail;
      logic j_end;
      logic walk_fail;
      logic walk_done;
      logic found;
      logic k_done;
      logic ins_now;
      logic rsp_free;
   } sts_type;

endpackage

// ===== rtl/skl_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module skl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/skl_ctrl.sv =====
// Sequencer for the packer: border init and clear, scan, walk, store rewrite, area update, response.
// Depends on skl_pkg for the command and status structs.
module skl_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  skl_pkg::sts_type sts,
   output skl_pkg::cmd_type cmd
);
   import skl_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_DECIDE, ST_CLR, ST_SCAN_RD, ST_SCAN_EV, ST_WALK_RD,
      ST_WALK_EV, ST_COPY_RD, ST_COPY_EV, ST_FLUSH, ST_MUL, ST_ADD, ST_RESP
   } state_type;

   state_type     state_ff, state_in;
   resp_kind_type kind_ff, kind_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      cmd = '0;
      cmd.resp_kind = kind_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_border = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (sts.mode) begin
               state_in = ST_CLR;
            end else if (sts.zero_or_full) begin
               kind_in = RESP_FAIL;
               state_in = ST_RESP;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_CLR: begin
            cmd.init_border = 1'b1;
            kind_in = RESP_CLEAR;
            state_in = ST_RESP;
         end
         ST_SCAN_RD: begin
            priority if (sts.i_done && sts.found) begin
               cmd.copy_init = 1'b1;
               state_in = ST_COPY_RD;
            end else if (sts.i_done) begin
               kind_in = RESP_FAIL;
               state_in = ST_RESP;
            end else begin
               cmd.start_rd = 1'b1;
               state_in = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            if (sts.x_fail) begin
               cmd.next_start = 1'b1;
               state_in = ST_SCAN_RD;
            end else begin
               cmd.start_ev = 1'b1;
               state_in = ST_WALK_EV;
            end
         end
         ST_WALK_RD: begin
            if (sts.j_end) begin
               cmd.next_start = 1'b1;
               state_in = ST_SCAN_RD;
            end else begin
               cmd.walk_rd = 1'b1;
               state_in = ST_WALK_EV;
            end
         end
         ST_WALK_EV: begin
            cmd.walk_ev = 1'b1;
            if (sts.walk_fail || sts.walk_done) begin
               cmd.next_start = 1'b1;
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_COPY_RD: begin
            if (sts.k_done) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.copy_rd = 1'b1;
               state_in = ST_COPY_EV;
            end
         end
         ST_COPY_EV: begin
            cmd.copy_ev = 1'b1;
            if (!sts.ins_now) begin
               state_in = ST_COPY_RD;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.area_mul = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.area_add = 1'b1;
            kind_in = RESP_PLACE;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         kind_ff <= RESP_FAIL;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
      end
   end

endmodule

// ===== rtl/skl_dp.sv =====
// Datapath: atlas registers, two segment banks, scan and rewrite logic, area.
// Depends on skl_pkg and skl_ram.
module skl_dp #(
   parameter int MAX_SEGMENTS = skl_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  skl_pkg::cmd_type              cmd,
   output skl_pkg::sts_type              sts,
   input  logic                          req_mode,
   input  logic [skl_pkg::DIM_W-1:0]     req_rect_width,
   input  logic [skl_pkg::DIM_W-1:0]     req_rect_height,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_placed,
   output logic [skl_pkg::DIM_W-1:0]     rsp_pos_x,
   output logic [skl_pkg::DIM_W-1:0]     rsp_pos_y,
   output logic [skl_pkg::AREA_W-1:0]    rsp_used_area,
   input  logic                          csr_valid,
   input  logic [skl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [skl_pkg::DIM_W-1:0]     csr_data
);
   import skl_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   logic [DIM_W-1:0] aw_ff, ah_ff;
   logic             mode_ff;
   logic [DIM_W-1:0] w_ff, h_ff;
   logic [CW-1:0]    count_ff, i_ff, j_ff, k_ff, best_ff, wcnt_ff;
   logic             bank_ff;
   logic [DIM_W-1:0] y_ff, sx_ff, sw_ff, bx_ff, by_ff, bw_ff;
   logic signed [DIM_W+1:0] left_ff;
   logic             found_ff, ins_ff, shr_ff, pend_v_ff;
   logic [DIM_W:0]   btop_ff;
   seg_type          pend_ff;
   logic [AREA_W-1:0] prod_ff, area_ff;
   logic             rsp_valid_ff, rsp_placed_ff;
   logic [DIM_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [AREA_W-1:0] rsp_area_ff;

   logic [SEG_W-1:0] rd0, rd1;
   seg_type          d;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr0_en, wr1_en;
   logic [AW-1:0]    wr_addr;
   seg_type          wr_data;

   logic [DIM_W-1:0] ny;
   logic [DIM_W:0]   top;
   logic signed [DIM_W+1:0] nleft;
   logic             better;
   logic [DIM_W:0]   pe;
   logic signed [DIM_W+1:0] nw;
   logic             feed_v, wr_pend;
   seg_type          feed_s, pend_in;
   logic             pend_v_in, shr_in;
   seg_type          border;

   assign d = bank_ff ? seg_type'(rd1) : seg_type'(rd0);

   skl_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_bank0 (
      .clock(clock), .wr_en(wr0_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd0)
   );

   skl_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_bank1 (
      .clock(clock), .wr_en(wr1_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd1)
   );

   always_comb begin
      rd_en = cmd.start_rd || cmd.walk_rd || cmd.copy_rd;
      priority if (cmd.start_rd) begin
         rd_addr = i_ff[AW-1:0];
      end else if (cmd.walk_rd) begin
         rd_addr = j_ff[AW-1:0];
      end else begin
         rd_addr = k_ff[AW-1:0];
      end
   end

   // walk step
   always_comb begin
      ny = (d.y > y_ff) ? d.y : y_ff;
      top = {1'b0, ny} + {1'b0, h_ff};
      nleft = left_ff - $signed({2'b00, d.w});
      better = !found_ff || (top < btop_ff) || (top == btop_ff && sw_ff < bw_ff);
   end

   // rewrite stream: insert, shrink, merge
   always_comb begin
      border.x = 16'd1;
      border.y = 16'd1;
      border.w = (aw_ff >= 16'd2) ? aw_ff - 16'd2 : '0;
      pe = {1'b0, bx_ff} + {1'b0, w_ff};
      nw = $signed({2'b00, d.w}) + $signed({2'b00, d.x}) - $signed({1'b0, pe});
      feed_v = 1'b0;
      feed_s = d;
      shr_in = shr_ff;
      if (cmd.copy_ev) begin
         priority if (sts.ins_now) begin
            feed_v = 1'b1;
            feed_s.x = bx_ff;
            feed_s.y = by_ff + h_ff;
            feed_s.w = w_ff;
            shr_in = 1'b1;
         end else if (shr_ff && ({1'b0, d.x} < pe)) begin
            if (nw > 0) begin
               feed_v = 1'b1;
               feed_s.x = pe[DIM_W-1:0];
               feed_s.w = nw[DIM_W-1:0];
               shr_in = 1'b0;
            end
         end else begin
            feed_v = 1'b1;
            shr_in = 1'b0;
         end
      end
      pend_in = pend_ff;
      pend_v_in = pend_v_ff;
      wr_pend = cmd.flush;
      if (feed_v) begin
         if (pend_v_ff && pend_ff.y == feed_s.y) begin
            pend_in.w = pend_ff.w + feed_s.w;
         end else begin
            wr_pend = pend_v_ff;
            pend_in = feed_s;
            pend_v_in = 1'b1;
         end
      end
      wr0_en = 1'b0;
      wr1_en = 1'b0;
      if (cmd.init_border) begin
         wr_addr = '0;
         wr_data = border;
         wr0_en = !bank_ff;
         wr1_en = bank_ff;
      end else begin
         wr_addr = wcnt_ff[AW-1:0];
         wr_data = pend_ff;
         wr0_en = wr_pend && bank_ff;
         wr1_en = wr_pend && !bank_ff;
      end
   end

   always_comb begin
      sts.mode = mode_ff;
      sts.zero_or_full = (w_ff == '0) || (count_ff >= CW'(MAX_SEGMENTS));
      sts.i_done = (i_ff == count_ff);
      sts.x_fail = ({1'b0, d.x} + {1'b0, w_ff}) >= {1'b0, aw_ff};
      sts.j_end = (j_ff >= count_ff);
      sts.walk_fail = top >= {1'b0, ah_ff};
      sts.walk_done = (nleft <= 0);
      sts.found = found_ff;
      sts.k_done = (k_ff == count_ff);
      sts.ins_now = !ins_ff && (k_ff == best_ff);
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff <= ATLAS_WIDTH_RST;
         ah_ff <= ATLAS_HEIGHT_RST;
         count_ff <= CW'(1);
         bank_ff <= 1'b0;
         area_ff <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_ATLAS_WIDTH) begin
            aw_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_ATLAS_HEIGHT) begin
            ah_ff <= csr_data;
         end
         if (cmd.init_border) begin
            count_ff <= CW'(1);
            area_ff <= '0;
         end
         if (cmd.flush) begin
            count_ff <= wcnt_ff + CW'(1);
            bank_ff <= !bank_ff;
         end
         if (cmd.area_add) begin
            area_ff <= ({1'b0, area_ff} + {1'b0, prod_ff}) > {1'b0, {AREA_W{1'b1}}} ?
               {AREA_W{1'b1}} : area_ff + prod_ff;
         end
         if (cmd.scan_start) begin
            found_ff <= 1'b0;
         end else if (cmd.walk_ev && !sts.walk_fail && sts.walk_done && better) begin
            found_ff <= 1'b1;
         end
         if (cmd.copy_init) begin
            pend_v_ff <= 1'b0;
         end else begin
            pend_v_ff <= pend_v_in;
         end
         if (cmd.resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         w_ff <= req_rect_width;
         h_ff <= req_rect_height;
      end
      if (cmd.scan_start) begin
         i_ff <= '0;
      end else if (cmd.next_start) begin
         i_ff <= i_ff + CW'(1);
      end
      if (cmd.start_ev) begin
         y_ff <= d.y;
         left_ff <= $signed({2'b00, w_ff});
         j_ff <= i_ff;
         sx_ff <= d.x;
         sw_ff <= d.w;
      end else if (cmd.walk_ev) begin
         y_ff <= ny;
         left_ff <= nleft;
         j_ff <= j_ff + CW'(1);
      end
      if (cmd.walk_ev && !sts.walk_fail && sts.walk_done && better) begin
         btop_ff <= top;
         bw_ff <= sw_ff;
         best_ff <= i_ff;
         bx_ff <= sx_ff;
         by_ff <= ny;
      end
      if (cmd.copy_init) begin
         k_ff <= '0;
         wcnt_ff <= '0;
         ins_ff <= 1'b0;
         shr_ff <= 1'b0;
      end else if (cmd.copy_ev) begin
         shr_ff <= shr_in;
         if (sts.ins_now) begin
            ins_ff <= 1'b1;
         end else begin
            k_ff <= k_ff + CW'(1);
         end
         if (wr_pend) begin
            wcnt_ff <= wcnt_ff + CW'(1);
         end
      end
      pend_ff <= pend_in;
      if (cmd.area_mul) begin
         prod_ff <= {16'b0, w_ff} * {16'b0, h_ff};
      end
      if (cmd.resp_load) begin
         rsp_placed_ff <= (cmd.resp_kind != RESP_FAIL);
         rsp_x_ff <= (cmd.resp_kind == RESP_PLACE) ? bx_ff : '0;
         rsp_y_ff <= (cmd.resp_kind == RESP_PLACE) ? by_ff : '0;
         rsp_area_ff <= area_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_placed = rsp_placed_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;
   assign rsp_used_area = rsp_area_ff;

endmodule

// ===== rtl/skyline_rectangle_packer_core.sv =====
// Top level of the skyline rectangle packer.
// Depends on skl_pkg, skl_ctrl and skl_dp.

// Each place request reads the segment store one entry at a time, each in a read
// state and then an evaluate state: for each of the n segments a start read plus one
// read per further spanned segment, then n more reads to rewrite the skyline into
// the other bank, then flush, multiply and add steps; the single read port of the
// store sets this pace. Clear and reset rewrite the border segment in one write;
// a clear answers through the decide, clear and response states.
// A result waits in an output register while the next request is accepted.
module skyline_rectangle_packer_core #(
   parameter int MAX_SEGMENTS = skl_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [skl_pkg::DIM_W-1:0]     req_rect_width,
   input  logic [skl_pkg::DIM_W-1:0]     req_rect_height,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_placed,
   output logic [skl_pkg::DIM_W-1:0]     rsp_pos_x,
   output logic [skl_pkg::DIM_W-1:0]     rsp_pos_y,
   output logic [skl_pkg::AREA_W-1:0]    rsp_used_area,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [skl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [skl_pkg::DIM_W-1:0]     csr_data
);
   import skl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   skl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd)
   );

   skl_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_mode(req_mode), .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_placed(rsp_placed),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_used_area(rsp_used_area),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data)
   );

endmodule

// ===== rtl/skl_checker.sv =====
// Port-level checks for the skyline rectangle packer, bound to the top level.
// Depends on skl_pkg for widths.
module skl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_placed,
   input logic [skl_pkg::DIM_W-1:0]  rsp_pos_x,
   input logic [skl_pkg::DIM_W-1:0]  rsp_pos_y,
   input logic [skl_pkg::AREA_W-1:0] rsp_used_area
);
   import skl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_used_area) && $stable(rsp_placed))
      else $error("result beat changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_placed |-> rsp_pos_x == '0 && rsp_pos_y == '0)
      else $error("failed beat carries a position");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_placed && rsp_pos_x == '0 |-> rsp_pos_y == '0 && rsp_used_area == '0)
      else $error("clear beat carries area or position");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

endmodule

bind skyline_rectangle_packer_core skl_checker u_skl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_placed(rsp_placed),
   .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_used_area(rsp_used_area)
);

// ===== dv/skl_packer_checker.sv =====
// Checker for the skyline rectangle packer: watches the request, response and register
// channels, predicts every response and compares it field by field.
// Depends on skl_pkg.
module skl_packer_checker #(
   parameter int MAX_SEGMENTS = skl_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_mode,
   input  logic [skl_pkg::DIM_W-1:0]     req_rect_width,
   input  logic [skl_pkg::DIM_W-1:0]     req_rect_height,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_placed,
   input  logic [skl_pkg::DIM_W-1:0]     rsp_pos_x,
   input  logic [skl_pkg::DIM_W-1:0]     rsp_pos_y,
   input  logic [skl_pkg::AREA_W-1:0]    rsp_used_area,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [skl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [skl_pkg::DIM_W-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import skl_pkg::*;

   typedef struct packed {
      logic              placed;
      logic [DIM_W-1:0]  pos_x;
      logic [DIM_W-1:0]  pos_y;
      logic [AREA_W-1:0] used_area;
   } placement_type;

   logic [DIM_W-1:0]  atlas_w, atlas_h;
   logic [DIM_W-1:0]  sky_x [MAX_SEGMENTS];
   logic [DIM_W-1:0]  sky_y [MAX_SEGMENTS];
   logic [DIM_W-1:0]  sky_w [MAX_SEGMENTS];
   int                sky_n;
   logic [AREA_W-1:0] area_sum;
   placement_type     placements_due[$];

   function automatic void restore_border();
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         sky_x[i] = '0;
         sky_y[i] = '0;
         sky_w[i] = '0;
      end
      sky_x[0] = 1;
      sky_y[0] = 1;
      sky_w[0] = (atlas_w >= 2) ? atlas_w - 16'd2 : 16'd0;
      sky_n = 1;
      area_sum = '0;
   endfunction

   // rest height for a start at segment idx, -1 when it does not fit
   function automatic int rest_height(int idx, int w, int h);
      int limw, limh, y, left, i;
      limw = int'(atlas_w) - 1;
      limh = int'(atlas_h) - 1;
      y = sky_y[idx];
      left = w;
      i = idx;
      if (int'(sky_x[idx]) + w > limw) return -1;
      while (left > 0) begin
         if (i >= sky_n) return -1;
         if (int'(sky_y[i]) > y) y = sky_y[i];
         if (y + h > limh) return -1;
         left -= int'(sky_w[i]);
         i++;
      end
      return y;
   endfunction

   function automatic void drop_segment(int k);
      for (int j = k; j + 1 < sky_n; j++) begin
         sky_x[j] = sky_x[j+1];
         sky_y[j] = sky_y[j+1];
         sky_w[j] = sky_w[j+1];
      end
      sky_n--;
   endfunction

   function automatic placement_type pack_rect(logic mode, int w, int h);
      placement_type res;
      bit found;
      int best, best_top, best_w, bx, by, y, top, i, prev_end, nx, nw;
      logic [63:0] sum;
      res = '0;
      found = 0;
      best = 0; best_top = 0; best_w = 0; bx = 0; by = 0;
      if (mode) begin
         restore_border();
         res.placed = 1;
      end else if (w != 0 && sky_n < MAX_SEGMENTS) begin
         for (i = 0; i < sky_n; i++) begin
            y = rest_height(i, w, h);
            if (y >= 0) begin
               top = y + h;
               if (!found || top < best_top || (top == best_top && int'(sky_w[i]) < best_w)) begin
                  found = 1;
                  best_top = top;
                  best_w = sky_w[i];
                  best = i;
                  bx = sky_x[i];
                  by = y;
               end
            end
         end
         if (found) begin
            for (i = sky_n; i > best; i--) begin
               sky_x[i] = sky_x[i-1];
               sky_y[i] = sky_y[i-1];
               sky_w[i] = sky_w[i-1];
            end
            sky_x[best] = DIM_W'(bx);
            sky_y[best] = DIM_W'(by + h);
            sky_w[best] = DIM_W'(w);
            sky_n++;
            i = best + 1;
            while (i < sky_n) begin
               prev_end = int'(sky_x[i-1]) + int'(sky_w[i-1]);
               nx = sky_x[i];
               if (nx >= prev_end) break;
               nw = int'(sky_w[i]) - (prev_end - nx);
               if (nw <= 0) begin
                  drop_segment(i);
               end else begin
                  sky_x[i] = DIM_W'(prev_end);
                  sky_w[i] = DIM_W'(nw);
                  break;
               end
            end
            i = 0;
            while (i + 1 < sky_n) begin
               if (sky_y[i] == sky_y[i+1]) begin
                  sky_w[i] = sky_w[i] + sky_w[i+1];
                  drop_segment(i + 1);
               end else begin
                  i++;
               end
            end
            sum = 64'(area_sum) + 64'(w) * 64'(h);
            area_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            res.placed = 1;
            res.pos_x = DIM_W'(bx);
            res.pos_y = DIM_W'(by);
         end
      end
      res.used_area = area_sum;
      return res;
   endfunction

   assign pending = placements_due.size();

   always @(posedge clock) begin
      placement_type exp_p;
      if (reset) begin
         atlas_w = ATLAS_WIDTH_RST;
         atlas_h = ATLAS_HEIGHT_RST;
         restore_border();
         placements_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (placements_due.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               exp_p = placements_due.pop_front();
               if (rsp_placed !== exp_p.placed || rsp_pos_x !== exp_p.pos_x ||
                   rsp_pos_y !== exp_p.pos_y || rsp_used_area !== exp_p.used_area)
                  fail_count <= fail_count + 1;
               if (rsp_placed !== exp_p.placed)
                  $error("placed: expected %0d, got %0d", exp_p.placed, rsp_placed);
               if (rsp_pos_x !== exp_p.pos_x)
                  $error("pos_x: expected %0d, got %0d", exp_p.pos_x, rsp_pos_x);
               if (rsp_pos_y !== exp_p.pos_y)
                  $error("pos_y: expected %0d, got %0d", exp_p.pos_y, rsp_pos_y);
               if (rsp_used_area !== exp_p.used_area)
                  $error("used_area: expected %0d, got %0d", exp_p.used_area, rsp_used_area);
            end
         end
         if (req_valid && req_ready)
            placements_due.insert(placements_due.size(),
               pack_rect(req_mode, req_rect_width, req_rect_height));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ATLAS_WIDTH) atlas_w = csr_data;
            else if (csr_index == CSR_ATLAS_HEIGHT) atlas_h = csr_data;
         end
      end
   end
endmodule

// ===== dv/skyline_rectangle_packer_core_test.sv =====
// Top of the skyline packer testbench: clock, reset, request and register stimulus,
// response back-pressure and the verdict. Depends on skl_pkg, the core and skl_packer_checker.
module skyline_rectangle_packer_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import skl_pkg::*;

   localparam int STALL_LIMIT = 400000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0, req_mode = 0;
   logic [DIM_W-1:0]     req_rect_width = 0, req_rect_height = 0;
   logic                 req_ready;
   logic                 rsp_valid, rsp_placed;
   logic                 rsp_ready = 0;
   logic [DIM_W-1:0]     rsp_pos_x, rsp_pos_y;
   logic [AREA_W-1:0]    rsp_used_area;
   logic                 csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [DIM_W-1:0]     csr_data = 0;
   int                   fail_count, pending;
   int                   stall_cycles = 0;
   int                   cur_w = 512, cur_h = 512;
   bit                   quiet = 0;

   skyline_rectangle_packer_core uut (.*);
   skl_packer_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL skyline_rectangle_packer_core");
         $finish;
      end
   end

   // response back-pressure in bursts
   int rsp_burst = 0;
   always @(posedge clock) begin
      if (rsp_burst > 0) begin
         rsp_burst <= rsp_burst - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 0;
         rsp_burst <= $urandom_range(0, 17);
      end else begin
         rsp_ready <= 1;
      end
   end

   function automatic int idle_gap();
      if (quiet || $urandom_range(0, 5) != 0) return 0;
      return $urandom_range(1, 18);
   endfunction

   task automatic send_beat(int mode, int w, int h);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= (mode != 0);
      req_rect_width <= DIM_W'(w);
      req_rect_height <= DIM_W'(h);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= DIM_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_ATLAS_WIDTH) cur_w = val;
      else cur_h = val;
   endtask

   task automatic set_atlas(int w, int h);
      drain();
      write_reg(CSR_ATLAS_WIDTH, w);
      write_reg(CSR_ATLAS_HEIGHT, h);
      csr_valid <= 0;
   endtask

   function automatic int pick_dim(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return int'($urandom_range(0, 65535));
      if (r < 8) return ($urandom_range(0, 1) != 0) ? 65535 : 0;
      return $urandom_range(1, (span / 6 > 1) ? span / 6 : 1);
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0)
            send_beat(1, int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
         else
            send_beat(0, pick_dim(cur_w), pick_dim(cur_h));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed beats on the reset atlas
      send_beat(0, 0, 10);
      send_beat(0, 510, 1);
      send_beat(0, 1, 0);
      send_beat(0, 511, 1);
      send_beat(0, 10, 510);
      send_beat(0, 65535, 65535);
      send_beat(0, 100, 100);
      send_beat(0, 50, 200);
      send_beat(0, 100, 100);
      send_beat(1, 65535, 65535);
      send_beat(0, 510, 509);
      send_beat(0, 1, 1);
      send_beat(1, 0, 0);
      // largest atlas: one near-full placement, then beats that no longer fit
      set_atlas(65535, 65535);
      send_beat(1, 0, 0);
      send_beat(0, 65533, 65533);
      send_beat(0, 1, 1);
      send_beat(0, 1, 1);
      // narrow atlas: border segment has no width
      set_atlas(1, 100);
      send_beat(1, 0, 0);
      send_beat(0, 1, 1);
      send_beat(0, 0, 0);
      // staircase until the segment store is full
      set_atlas(1000, 1000);
      send_beat(1, 0, 0);
      for (int k = 1; k <= skl_pkg::MAX_SEGMENTS_DEF + 2; k++)
         send_beat(0, 1, k);
      send_beat(1, 0, 0);
      // random phases
      set_atlas(512, 512);
      send_beat(1, 0, 0);
      random_items(60);
      drain();
      random_items(30);
      set_atlas(3, 3);
      send_beat(1, 0, 0);
      random_items(60);
      set_atlas(100, 60);
      send_beat(1, 0, 0);
      random_items(60);
      set_atlas(40, 700);
      send_beat(1, 0, 0);
      random_items(50);
      // widen without clear so spans can run past the last segment
      set_atlas(200, 700);
      random_items(60);
      set_atlas(700, 40);
      send_beat(1, 0, 0);
      random_items(50);
      set_atlas(65535, 65535);
      send_beat(1, 0, 0);
      random_items(40);
      set_atlas(300, 300);
      send_beat(1, 0, 0);
      quiet = 1;
      random_items(60);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("PASS skyline_rectangle_packer_core");
      else
         $display("FAIL skyline_rectangle_packer_core");
      $finish;
   end
endmodule
